>>> hdl/rgbhsv_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV converter.
// Depends on nothing; every module of the converter imports it.
package rgbhsv_pkg;

  localparam int PIX_W = 8;
  localparam int QUO_W = 16;
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;
  localparam int HNUM_W = 20;
  localparam int HQ_W = 12;

  localparam int HUE_SECTOR = 3840;
  localparam int HUE_OFF_G = 7680;
  localparam int HUE_OFF_B = 15360;
  localparam int HUE_FULL = 23040;
  localparam int SAT_ONE = 32768;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // partial remainder and numerator bits still to bring down / quotient bits so far
  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [QUO_W-1:0] word;
  } lane_t;

  typedef struct packed {
    lane_t            hue;
    lane_t            sat;
    logic [PIX_W-1:0] delta;
    logic [PIX_W-1:0] bright;
    sector_t          sector;
    logic             neg;
    logic             last;
  } stage_t;

  // one restoring division step: bring down the next bit, subtract if it fits
  function automatic lane_t div_step(lane_t cur, logic [PIX_W-1:0] dvs);
    logic [PIX_W:0]   part;
    logic [PIX_W+1:0] trial;
    lane_t            res;
    part     = {cur.rem, cur.word[QUO_W-1]};
    trial    = {1'b0, part} - {2'b00, dvs};
    res.word = {cur.word[QUO_W-2:0], ~trial[PIX_W+1]};
    res.rem  = trial[PIX_W+1] ? part[PIX_W-1:0] : trial[PIX_W-1:0];
    return res;
  endfunction

endpackage

>>> hdl/rgb_to_hsv_pixel_converter_core.sv
// RGB to HSV converter top level: input stage, divider cell row, output stage.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_cell and rgbhsv_back.
//
//   channel  direction  handshake          payload
//   in_      sink       in_valid/in_stall   red, green, blue, last_pixel
//   out_     source     out_valid/out_stall hue, saturation, brightness, end_of_image
//
// One pixel per clock sustained while out_stall stays low; a beat passes through
// one input stage, sixteen divider cells (one quotient bit each) and one output
// register.
// Reset clears the valid flags only; payload registers are not reset.
// A stall on out_ ripples back through the row one stage per empty slot,
// so in_stall rises only when every stage holds a beat.
module rgb_to_hsv_pixel_converter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  in_red,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  in_green,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  in_blue,
  input  logic                          in_last_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rgbhsv_pkg::HUE_W-1:0]  out_hue,
  output logic [rgbhsv_pkg::SAT_W-1:0]  out_saturation,
  output logic [rgbhsv_pkg::PIX_W-1:0]  out_brightness,
  output logic                          out_end_of_image
);
  import rgbhsv_pkg::*;

  stage_t st  [0:QUO_W];
  logic   vld [0:QUO_W];
  logic   rdy [0:QUO_W];

  rgbhsv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_stall   (in_stall),
    .red        (in_red),
    .green      (in_green),
    .blue       (in_blue),
    .last_pixel (in_last_pixel),
    .dn_valid   (vld[0]),
    .dn_data    (st[0]),
    .dn_ready   (rdy[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[k]),
      .up_data  (st[k]),
      .up_ready (rdy[k]),
      .dn_valid (vld[k+1]),
      .dn_data  (st[k+1]),
      .dn_ready (rdy[k+1])
    );
  end

  rgbhsv_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (vld[QUO_W]),
    .up_data      (st[QUO_W]),
    .up_ready     (rdy[QUO_W]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hue          (out_hue),
    .saturation   (out_saturation),
    .brightness   (out_brightness),
    .end_of_image (out_end_of_image)
  );

`ifndef NO_ASSERTIONS
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= SAT_W'(SAT_ONE))
    else $error("saturation above one");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_W'(HUE_FULL))
    else $error("hue not wrapped");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == '0) |-> out_hue == '0)
    else $error("grey pixel with non-zero hue");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && vld[0]))
    else $error("input stalled with room in the row");
`endif

endmodule

>>> hdl/rgbhsv_front.sv
// Input stage: max, min, delta, hue sector and the two dividend set-ups.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_stall,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  red,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  green,
  input  logic [rgbhsv_pkg::PIX_W-1:0]  blue,
  input  logic                          last_pixel,
  output logic                          dn_valid,
  output rgbhsv_pkg::stage_t            dn_data,
  input  logic                          dn_ready
);
  import rgbhsv_pkg::*;

  logic              valid_r;
  stage_t            data_r;
  stage_t            data_nxt;
  logic              ready;
  logic [PIX_W-1:0]  mx;
  logic [PIX_W-1:0]  mn;
  logic [PIX_W-1:0]  delta;
  logic [PIX_W-1:0]  op_p;
  logic [PIX_W-1:0]  op_q;
  logic [PIX_W-1:0]  mag;
  logic [HNUM_W-1:0] hnum;
  sector_t           sector;
  logic              neg;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    priority if (mx == red) begin
      sector = SEC_RED;
    end else if (mx == green) begin
      sector = SEC_GREEN;
    end else begin
      sector = SEC_BLUE;
    end

    unique case (sector)
      SEC_RED: begin
        op_p = green;
        op_q = blue;
      end
      SEC_GREEN: begin
        op_p = blue;
        op_q = red;
      end
      SEC_BLUE: begin
        op_p = red;
        op_q = green;
      end
      default: begin
        op_p = red;
        op_q = green;
      end
    endcase

    neg  = op_p < op_q;
    mag  = neg ? (op_q - op_p) : (op_p - op_q);
    hnum = HNUM_W'(32'(mag) * HUE_SECTOR);

    data_nxt.hue.rem  = {{(PIX_W-(HNUM_W-QUO_W)){1'b0}}, hnum[HNUM_W-1:QUO_W]};
    data_nxt.hue.word = hnum[QUO_W-1:0];
    data_nxt.sat.rem  = {1'b0, delta[PIX_W-1:1]};
    data_nxt.sat.word = {delta[0], {(QUO_W-1){1'b0}}};
    data_nxt.delta    = delta;
    data_nxt.bright   = mx;
    data_nxt.sector   = sector;
    data_nxt.neg      = neg;
    data_nxt.last     = last_pixel;
  end

  assign ready    = !valid_r || dn_ready;
  assign up_stall = !ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/rgbhsv_cell.sv
// Divider cell: one quotient bit for hue and one for saturation per beat.
// Depends on rgbhsv_pkg.
module rgbhsv_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  rgbhsv_pkg::stage_t  up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output rgbhsv_pkg::stage_t  dn_data,
  input  logic                dn_ready
);
  import rgbhsv_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  always_comb begin
    data_nxt     = up_data;
    data_nxt.hue = div_step(up_data.hue, up_data.delta);
    data_nxt.sat = div_step(up_data.sat, up_data.bright);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/rgbhsv_back.sv
// Output stage: sign, sector offset and wrap of the hue, grey override,
// and the output register. Depends on rgbhsv_pkg.
module rgbhsv_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  input  rgbhsv_pkg::stage_t            up_data,
  output logic                          up_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
  output logic [rgbhsv_pkg::SAT_W-1:0]  saturation,
  output logic [rgbhsv_pkg::PIX_W-1:0]  brightness,
  output logic                          end_of_image
);
  import rgbhsv_pkg::*;

  logic             valid_r;
  logic [HUE_W-1:0] hue_r;
  logic [SAT_W-1:0] sat_r;
  logic [PIX_W-1:0] bright_r;
  logic             last_r;
  logic [HUE_W-1:0] hue_nxt;
  logic [SAT_W-1:0] sat_nxt;
  logic [HUE_W-1:0] quo;
  logic [HUE_W-1:0] base;
  logic             grey;

  always_comb begin
    quo  = {{(HUE_W-HQ_W){1'b0}}, up_data.hue.word[HQ_W-1:0]};
    grey = up_data.delta == '0;
    unique case (up_data.sector)
      SEC_RED:   base = (up_data.neg && quo != '0) ? HUE_W'(HUE_FULL) : '0;
      SEC_GREEN: base = HUE_W'(HUE_OFF_G);
      SEC_BLUE:  base = HUE_W'(HUE_OFF_B);
      default:   base = '0;
    endcase
    hue_nxt = up_data.neg ? (base - quo) : (base + quo);
    sat_nxt = up_data.sat.word;
    if (grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  assign up_ready     = !valid_r || !out_stall;
  assign out_valid    = valid_r;
  assign hue          = hue_r;
  assign saturation   = sat_r;
  assign brightness   = bright_r;
  assign end_of_image = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= up_data.bright;
      last_r   <= up_data.last;
    end
  end

endmodule

>>> verif/rgb_to_hsv_pixel_converter_core_test.sv
// Testbench for rgb_to_hsv_pixel_converter_core: drives pixels, stalls the result channel
// and checks every HSV beat against a predictor held in a small scoreboard class.
// Depends on rgbhsv_pkg and the converter RTL only.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_converter_core_test;
  import rgbhsv_pkg::*;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [PIX_W-1:0] bright;
    logic             eoi;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t expected_hsv[$];
    int   errors = 0;
    int   pixels = 0;
    int   results = 0;
    int   grays = 0;
    int   wraps = 0;
    int   sectors[3] = '{0, 0, 0};

    function int pending();
      return expected_hsv.size();
    endfunction

    function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] b, logic last);
      hsv_t    e;
      int      top;
      int      bottom;
      int      span;
      int      diff;
      int      base;
      int      h;
      int      s;
      sector_t sec;
      top = int'(r);
      bottom = int'(r);
      if (int'(g) > top) top = int'(g);
      if (int'(b) > top) top = int'(b);
      if (int'(g) < bottom) bottom = int'(g);
      if (int'(b) < bottom) bottom = int'(b);
      span = top - bottom;
      h = 0;
      s = 0;
      if (span == 0) begin
        grays++;
      end else begin
        if (top == int'(r)) sec = SEC_RED;
        else if (top == int'(g)) sec = SEC_GREEN;
        else sec = SEC_BLUE;
        case (sec)
          SEC_RED: begin
            diff = int'(g) - int'(b);
            base = 0;
          end
          SEC_GREEN: begin
            diff = int'(b) - int'(r);
            base = HUE_OFF_G;
          end
          default: begin
            diff = int'(r) - int'(g);
            base = HUE_OFF_B;
          end
        endcase
        sectors[sec]++;
        h = (HUE_SECTOR * diff) / span + base;
        if (h < 0) begin
          h += HUE_FULL;
          wraps++;
        end
        s = (span * SAT_ONE) / top;
      end
      e.hue = h[HUE_W-1:0];
      e.sat = s[SAT_W-1:0];
      e.bright = top[PIX_W-1:0];
      e.eoi = last;
      expected_hsv.insert(expected_hsv.size(), e);
      pixels++;
    endfunction

    function void check_result(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                               logic [PIX_W-1:0] bright, logic eoi);
      hsv_t e;
      results++;
      if (expected_hsv.size() == 0) begin
        $error("unexpected beat: hue %0d saturation %0d brightness %0d end_of_image %0b",
               hue, sat, bright, eoi);
        errors++;
        return;
      end
      e = expected_hsv.pop_front();
      if (hue !== e.hue) begin
        $error("hue: expected %0d, got %0d", e.hue, hue);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturation: expected %0d, got %0d", e.sat, sat);
        errors++;
      end
      if (bright !== e.bright) begin
        $error("brightness: expected %0d, got %0d", e.bright, bright);
        errors++;
      end
      if (eoi !== e.eoi) begin
        $error("end_of_image: expected %0b, got %0b", e.eoi, eoi);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_red = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_blue = '0;
  logic             in_last_pixel = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HUE_W-1:0] out_hue;
  logic [SAT_W-1:0] out_saturation;
  logic [PIX_W-1:0] out_brightness;
  logic             out_end_of_image;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  hsv_scoreboard sb = new();

  rgb_to_hsv_pixel_converter_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_last_pixel    (in_last_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hue          (out_hue),
    .out_saturation   (out_saturation),
    .out_brightness   (out_brightness),
    .out_end_of_image (out_end_of_image)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_red, in_green, in_blue, in_last_pixel);
      if (out_valid && !out_stall)
        sb.check_result(out_hue, out_saturation, out_brightness, out_end_of_image);
    end
  end

  function automatic int pick_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] b, logic last);
    int n;
    n = pick_wait(tx_calm);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_last_pixel <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] v;
    logic             last;
    int               kind;
    r = PIX_W'($urandom);
    g = PIX_W'($urandom);
    b = PIX_W'($urandom);
    kind = int'($urandom_range(0, 99));
    if (kind < 10) begin
      g = r;
      b = r;
    end else if (kind < 25) begin
      v = r;
      case ($urandom_range(0, 2))
        0: begin g = v; b = PIX_W'($urandom_range(0, v)); end
        1: begin b = v; r = PIX_W'($urandom_range(0, v)); end
        default: begin b = v; g = v; r = PIX_W'($urandom_range(0, v)); end
      endcase
    end else if (kind < 35) begin
      r = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
      g = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
      b = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
    end else if (kind < 50) begin
      v = PIX_W'($urandom_range(3, 252));
      r = v + 8'($urandom_range(0, 6)) - 8'd3;
      g = v + 8'($urandom_range(0, 6)) - 8'd3;
      b = v + 8'($urandom_range(0, 6)) - 8'd3;
    end
    last = ($urandom_range(0, 15) == 0);
    send_pixel(r, g, b, last);
  endtask

  initial begin
    int n;
    forever begin
      n = pick_wait(rx_calm);
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      if (sb.results % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd254, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
    send_pixel(8'd255, 8'd1, 8'd0, 1'b0);
    send_pixel(8'd200, 8'd10, 8'd100, 1'b0);
    send_pixel(8'd10, 8'd200, 8'd100, 1'b0);
    send_pixel(8'd100, 8'd10, 8'd200, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd85, 8'd170, 8'd85, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd170, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
    drain_results();

    for (int i = 0; i < 1400; i++) begin
      if (i % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (i == 700) drain_results();
      send_random_pixel();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Converted %0d pixels into %0d beats: %0d grey, %0d/%0d/%0d by red/green/blue sector",
             sb.pixels, sb.results, sb.grays, sb.sectors[SEC_RED], sb.sectors[SEC_GREEN],
             sb.sectors[SEC_BLUE]);
    $display("%0d hues wrapped from negative, random idling on both channels", sb.wraps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Timed out with %0d beats outstanding", sb.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
